// ----- hdl/pca_pkg.sv -----
// Shared types and constants for the palette colour allocator.
// No dependencies; imported by pca_ctrl, pca_datapath and palette_color_allocator.
package pca_pkg;

  localparam int COMP_W   = 6;
  localparam int COLOUR_W = 3 * COMP_W;
  localparam int IDX_W    = 8;
  localparam int STAT_W   = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOW_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } pca_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;    // capture the input word and rewind the scan
    logic advance;  // issue the next read and shift the compare stage
    logic commit;   // load the result register, insert on a miss
  } pca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;        // compare stage holds a matching entry
    logic done;       // every stored entry compared without a match
    logic slot_free;  // result register can take a word this cycle
  } pca_stat_t;

endpackage

// ----- hdl/pca_ctrl.sv -----
// Controller for the palette colour allocator: sequences accept, scan and commit.
// Depends on pca_pkg.
module pca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pca_pkg::pca_stat_t stat,
  output pca_pkg::pca_cmd_t  cmd
);
  import pca_pkg::*;

  pca_state_t state_r;
  pca_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Stop on the first hit or at the end; wait for the result register
        if (stat.hit || stat.done) begin
          if (stat.slot_free) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/pca_datapath.sv -----
// Datapath for the palette colour allocator: palette memory, entry count,
// scan pipeline and result register. Depends on pca_pkg.
module pca_datapath #(
  parameter int ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pca_pkg::COMP_W-1:0]   in_red,
  input  logic [pca_pkg::COMP_W-1:0]   in_green,
  input  logic [pca_pkg::COMP_W-1:0]   in_blue,
  input  pca_pkg::pca_cmd_t            cmd,
  output pca_pkg::pca_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pca_pkg::IDX_W-1:0]    out_index,
  output logic [pca_pkg::STAT_W-1:0]   out_status
);
  import pca_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  logic [COLOUR_W-1:0] mem [ENTRIES];

  logic [COLOUR_W-1:0] key_r;
  logic [CW-1:0]       scan_r;
  logic [CW-1:0]       count_r;
  logic [COLOUR_W-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [AW-1:0]       cmp_addr_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [STAT_W-1:0]   out_status_r;

  logic                issue;
  logic                table_full;
  logic                insert;
  logic [XW-1:0]       hit_idx_wide;
  logic [XW-1:0]       ins_idx_wide;

  assign issue        = scan_r < count_r;
  assign table_full   = count_r == CW'(ENTRIES);
  assign insert       = cmd.commit && !stat.hit && !table_full;
  assign hit_idx_wide = XW'(cmp_addr_r);
  assign ins_idx_wide = XW'(count_r[AW-1:0]);

  // Status towards the controller
  assign stat.hit       = rd_vld_r && (rd_data_r == key_r);
  assign stat.done      = !rd_vld_r && !issue;
  assign stat.slot_free = !out_valid_r || out_ready;

  // Capture the colour word and rewind the scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r  <= {in_red, in_green, in_blue};
      scan_r <= '0;
    end else if (cmd.advance && issue) begin
      scan_r <= scan_r + CW'(1);
    end
  end

  // Read port: one stored entry a cycle while the scan advances, registered
  always_ff @(posedge clk) begin
    if (cmd.advance && issue) begin
      rd_data_r  <= mem[scan_r[AW-1:0]];
      cmp_addr_r <= scan_r[AW-1:0];
    end
  end

  // Write port: append a missed colour
  always_ff @(posedge clk) begin
    if (insert) begin
      mem[count_r[AW-1:0]] <= key_r;
    end
  end

  // Compare stage valid and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cmd.start) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.advance) begin
        rd_vld_r <= issue;
      end
      if (insert) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (stat.hit) begin
        out_index_r  <= hit_idx_wide[IDX_W-1:0];
        out_status_r <= STAT_FOUND;
      end else if (table_full) begin
        out_index_r  <= '0;
        out_status_r <= STAT_REJECTED;
      end else begin
        out_index_r  <= ins_idx_wide[IDX_W-1:0];
        out_status_r <= (count_r == CW'(ENTRIES - 1)) ? STAT_NOW_FULL : STAT_INSERTED;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

endmodule

// ----- hdl/palette_color_allocator.sv -----
// Top level of the palette colour allocator: controller plus datapath.
// Depends on pca_pkg, pca_ctrl and pca_datapath.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+---------------------------
//   input   | in_valid, in_ready                      | in_red, in_green, in_blue
//   result  | out_valid, out_ready                    | out_index, out_status
//
// An item's scan compares the stored entries in order up to the first hit
// (all of them on a miss): the single read port of the palette memory
// delivers one entry a cycle. Reset clears the entry count, so the table
// starts empty without a clearing pass. A new item is taken while the
// previous result waits; the commit then holds until the result register
// is free.
module palette_color_allocator #(
  parameter int ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pca_pkg::COMP_W-1:0]   in_red,
  input  logic [pca_pkg::COMP_W-1:0]   in_green,
  input  logic [pca_pkg::COMP_W-1:0]   in_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pca_pkg::IDX_W-1:0]    out_index,
  output logic [pca_pkg::STAT_W-1:0]   out_status
);
  import pca_pkg::*;

  pca_cmd_t  cmd;
  pca_stat_t stat;

  pca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pca_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_index),
    .out_status (out_status)
  );

  // Commit only into a free result register
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.slot_free)
    else $error("commit while result register busy");

  // Never scan and commit in the same cycle
  a_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.advance && !cmd.start)
    else $error("commit overlaps scan or start");

  // An accepted word closes the input until its result is committed
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened during scan");

  // A commit always presents a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit lost its result");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for palette_color_allocator: colour words in, index and status out.
// Depends on pca_pkg and the palette_color_allocator RTL; a shadow palette predicts each result.
module testbench;
  import pca_pkg::*;

  localparam int PALETTE_SIZE    = 256;
  localparam int POST_FULL_ITEMS = 180;
  localparam int HOLD_AFTER      = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PRINT_LIMIT     = 50;
  localparam int N_OPENING       = 18;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } colour_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
  } palette_result_t;

  typedef struct {
    colour_t         colour;
    bit              stated;
    palette_result_t want;
  } opening_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [COMP_W-1:0] in_red    = '0;
  logic [COMP_W-1:0] in_green  = '0;
  logic [COMP_W-1:0] in_blue   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_index;
  logic [STAT_W-1:0] out_status;

  // Shadow of the palette and its fill level
  colour_t         shadow_palette [PALETTE_SIZE];
  int              stored_count = 0;
  palette_result_t pending_results [$];
  int              mismatch_count = 0;
  int              results_seen = 0;
  int              burst_left = 0;

  // Directed opening: extremes, repeats, near matches one bit apart
  opening_row_t opening_rows [N_OPENING] = '{
    '{'{6'd0,  6'd0,  6'd0},  1'b1, '{8'd0, STAT_INSERTED}},
    '{'{6'd63, 6'd63, 6'd63}, 1'b1, '{8'd1, STAT_INSERTED}},
    '{'{6'd0,  6'd0,  6'd0},  1'b1, '{8'd0, STAT_FOUND}},
    '{'{6'd63, 6'd63, 6'd63}, 1'b1, '{8'd1, STAT_FOUND}},
    '{'{6'd63, 6'd0,  6'd0},  1'b1, '{8'd2, STAT_INSERTED}},
    '{'{6'd0,  6'd63, 6'd0},  1'b1, '{8'd3, STAT_INSERTED}},
    '{'{6'd0,  6'd0,  6'd63}, 1'b1, '{8'd4, STAT_INSERTED}},
    '{'{6'd63, 6'd0,  6'd0},  1'b1, '{8'd2, STAT_FOUND}},
    '{'{6'd63, 6'd63, 6'd62}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd62, 6'd63, 6'd63}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd63, 6'd62, 6'd63}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd42, 6'd21, 6'd42}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd21, 6'd42, 6'd21}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd0,  6'd0,  6'd63}, 1'b1, '{8'd4, STAT_FOUND}},
    '{'{6'd21, 6'd42, 6'd21}, 1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd1,  6'd0,  6'd0},  1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd0,  6'd0,  6'd1},  1'b0, '{8'd0, STAT_FOUND}},
    '{'{6'd0,  6'd0,  6'd0},  1'b1, '{8'd0, STAT_FOUND}}
  };

  palette_color_allocator #(
    .ENTRIES(PALETTE_SIZE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_status(out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Search the shadow palette in order; append on a miss while there is room
  function automatic palette_result_t lookup_or_insert(input colour_t colour);
    palette_result_t res;
    int hit;
    hit = -1;
    for (int i = 0; i < stored_count; i++) begin
      if (hit < 0 && shadow_palette[i] == colour) hit = i;
    end
    if (hit >= 0) begin
      res.index  = hit[IDX_W-1:0];
      res.status = STAT_FOUND;
    end else if (stored_count >= PALETTE_SIZE) begin
      res.index  = '0;
      res.status = STAT_REJECTED;
    end else begin
      shadow_palette[stored_count] = colour;
      res.index    = stored_count[IDX_W-1:0];
      stored_count = stored_count + 1;
      res.status   = (stored_count >= PALETTE_SIZE) ? STAT_NOW_FULL : STAT_INSERTED;
    end
    return res;
  endfunction

  // Fresh colour, a stored one, or a stored one with a single bit flipped
  function automatic colour_t pick_colour(input int fresh_pct, input int stored_pct);
    colour_t colour;
    int coin;
    int slot;
    coin = $urandom_range(0, 99);
    slot = $urandom_range(0, stored_count - 1);
    // lean on the ends of the table now and then
    case ($urandom_range(0, 7))
      0: slot = 0;
      1: slot = stored_count - 1;
      default: ;
    endcase
    if (coin < fresh_pct) begin
      colour.red   = COMP_W'($urandom_range(0, 63));
      colour.green = COMP_W'($urandom_range(0, 63));
      colour.blue  = COMP_W'($urandom_range(0, 63));
    end else if (coin < fresh_pct + stored_pct) begin
      colour = shadow_palette[slot];
    end else begin
      colour = shadow_palette[slot] ^ (18'd1 << $urandom_range(0, COLOUR_W - 1));
    end
    return colour;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word in bursts with gaps; record its expected result on acceptance
  task automatic offer_colour(input colour_t colour, input bit stated,
                              input palette_result_t stated_res);
    palette_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_red   <= colour.red;
    in_green <= colour.green;
    in_blue  <= colour.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    predicted = lookup_or_insert(colour);
    pending_results.push_back(stated ? stated_res : predicted);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_OPENING; r++)
      offer_colour(opening_rows[r].colour, opening_rows[r].stated, opening_rows[r].want);
    // fill the table, mostly with fresh colours
    while (stored_count < PALETTE_SIZE)
      offer_colour(pick_colour(60, 30), 1'b0, '0);
    // full table: hits anywhere, misses get rejected
    repeat (POST_FULL_ITEMS)
      offer_colour(pick_colour(40, 50), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Receiver: runs of ready with short stalls, one long hold-off to back up the input
  initial begin : result_sink
    bit held_off;
    int stall;
    held_off = 1'b0;
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    palette_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, index", int'(out_index), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_index !== want.index)
          report_mismatch("index", int'(out_index), int'(want.index));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Abort when neither channel moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
